### hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'h0f;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  character;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } out_item_t;

  typedef struct packed {
    logic put;          // apply a put: cell write and cursor advance
    logic clear;        // home the cursor
    logic read_start;   // issue a cell read at cell_index
    logic sweep_start;  // rewind the buffer sweep
    logic sweep_copy;   // sweep shifts rows up (scroll) instead of blanking all
    logic sweep_step;   // advance the sweep by one cell
    logic out_load;     // load the result register
    logic out_read;     // result carries the read cell
    logic out_sweep;    // result carries the scroll flag of the sweep
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       put_scroll;
    logic       read_ok;
    logic       sweep_last;
  } tcw_status_t;

endpackage

### hw/rtl/tcw_datapath.sv
// Datapath: screen buffer, cursor, attribute register, sweep counter, result register.
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::in_item_t   in_data,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  tcw_pkg::tcw_cmd_t   cmd,
  output tcw_pkg::tcw_status_t st,
  output tcw_pkg::out_item_t  out_data
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  logic [15:0] mem [CELL_COUNT];

  logic [7:0]       attr;
  logic [ROW_W-1:0] cursor_row_reg, cursor_row_next;
  logic [COL_W-1:0] cursor_col_reg, cursor_col_next;

  logic [ADDR_W-1:0] cnt;
  logic              sweep_copy_reg;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr_d;
  logic              wr_copy_d;
  logic [15:0]       rdata;

  // put arithmetic
  logic             newline;
  logic [COL_W:0]   col_inc;
  logic             wrap;
  logic             put_scroll;
  logic [ROW_W-1:0] put_row;
  logic [COL_W-1:0] put_col;
  logic [ADDR_W-1:0] pos;
  logic [15:0]      blank;

  // sweep addressing
  logic              in_copy;
  logic [ADDR_W-1:0] src;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;

  always_comb begin
    newline = (in_data.character == tcw_pkg::NEWLINE_CODE);
    col_inc = {1'b0, cursor_col_reg} + (COL_W+1)'(1);
    wrap    = newline || (col_inc == (COL_W+1)'(COLUMNS));
    put_scroll = wrap && (cursor_row_reg == ROW_W'(ROWS - 1));
    if (put_scroll) begin
      put_row = ROW_W'(ROWS - 1);
      put_col = '0;
    end else if (wrap) begin
      put_row = cursor_row_reg + ROW_W'(1);
      put_col = '0;
    end else begin
      put_row = cursor_row_reg;
      put_col = col_inc[COL_W-1:0];
    end
    pos   = ADDR_W'(cursor_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col_reg);
    blank = {attr, tcw_pkg::SPACE_CODE};
  end

  always_comb begin
    cursor_row_next = cursor_row_reg;
    cursor_col_next = cursor_col_reg;
    if (cmd.clear) begin
      cursor_row_next = '0;
      cursor_col_next = '0;
    end else if (cmd.put) begin
      cursor_row_next = put_row;
      cursor_col_next = put_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr           <= tcw_pkg::ATTR_RESET;
      cursor_row_reg <= '0;
      cursor_col_reg <= '0;
      wr_pend        <= 1'b0;
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      cursor_row_reg <= cursor_row_next;
      cursor_col_reg <= cursor_col_next;
      wr_pend        <= cmd.sweep_step;
    end
  end

  // Sweep: a step reads the cell one row below, writing it or a blank next cycle.
  always_comb begin
    in_copy = sweep_copy_reg && (int'(cnt) < COPY_COUNT);
    src     = cnt + ADDR_W'(COLUMNS);
    if (cmd.read_start) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(in_data.cell_index);
    end else begin
      rd_en   = cmd.sweep_step && in_copy;
      rd_addr = src;
    end
    if (cmd.put && !newline) begin
      we      = 1'b1;
      wr_addr = pos;
      wr_data = {attr, in_data.character};
    end else begin
      we      = wr_pend;
      wr_addr = wr_addr_d;
      wr_data = wr_copy_d ? rdata : blank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      cnt            <= '0;
      sweep_copy_reg <= cmd.sweep_copy;
    end else if (cmd.sweep_step) begin
      cnt <= cnt + ADDR_W'(1);
    end
    wr_addr_d <= cnt;
    wr_copy_d <= in_copy;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.cell_value <= cmd.out_read ? rdata : 16'd0;
      out_data.cursor_row <= 5'(cursor_row_next);
      out_data.cursor_col <= 7'(cursor_col_next);
      out_data.scrolled   <= cmd.out_sweep && sweep_copy_reg;
    end
  end

  always_comb begin
    st.op         = in_data.operation;
    st.put_scroll = put_scroll;
    st.read_ok    = int'(in_data.cell_index) < CELL_COUNT;
    st.sweep_last = (cnt == ADDR_W'(CELL_COUNT - 1));
  end

endmodule

### hw/rtl/tcw_ctrl.sv
// Controller: operation sequencing and the result valid flag.
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tcw_pkg::tcw_status_t st,
  output tcw_pkg::tcw_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_valid_next;

  always_comb begin
    in_stall   = !((state == S_IDLE) && (!out_valid || !out_stall));
    accept     = in_valid && !in_stall;
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (st.op)
            tcw_pkg::OP_PUT: begin
              cmd.put = 1'b1;
              if (st.put_scroll) begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_copy  = 1'b1;
                state_next      = S_SWEEP;
              end else begin
                cmd.out_load = 1'b1;
              end
            end
            tcw_pkg::OP_READ: begin
              if (st.read_ok) begin
                cmd.read_start = 1'b1;
                state_next     = S_READ;
              end else begin
                cmd.out_load = 1'b1;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cmd.clear       = 1'b1;
              cmd.sweep_start = 1'b1;
              state_next      = S_SWEEP;
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.out_load = 1'b1;
        cmd.out_read = 1'b1;
        state_next   = S_IDLE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last delayed write lands this cycle
        cmd.out_load  = 1'b1;
        cmd.out_sweep = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/text_console_writer.sv
// Text console writer: ROWS x COLUMNS screen of 16-bit cells with a cursor.
// Input channel (in_valid / in_stall / in_data) takes one transaction per
// operation: put a character, read a cell, or clear the screen. The output
// channel (out_valid / out_stall / out_data) returns exactly one result per
// input transaction, in order, from a result register.
// A non-scrolling put loads the result at the accepting edge; a screen read
// first passes the memory read and the READ state. Puts go one per cycle
// unless a result waits under out_stall; nothing follows a read until its
// result is loaded. Scroll and clear walk the buffer one cell per cycle
// through the single memory write port, in_stall high for the whole walk.
// While a result waits under out_stall, in_stall stays high until the result
// register frees up.
// cfg_write loads the attribute byte (cfg_data) at once; write it only while
// no transaction is outstanding.
// Reset clears the cursor to the top-left corner, sets the attribute to 0x0f
// and empties the result register; the screen contents stay undefined until
// written by a put or a clear.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t st;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

### sim/text_console_writer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer: random console traffic against a shadow screen.
module text_console_writer_test;

  localparam int SCREEN_COLS     = 80;
  localparam int SCREEN_ROWS     = 25;
  localparam int SCREEN_CELLS    = SCREEN_COLS * SCREEN_ROWS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_COMMANDS = 1700;
  localparam int QUIET_LIMIT     = 20000;
  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 50;

  typedef struct {
    bit                marker;
    bit                cfg_en;
    bit [7:0]          cfg_val;
    int                gap_pct;
    int                stall_pct;
    bit                last;
    tcw_pkg::in_item_t cmd;
  } backlog_entry_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tcw_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tcw_pkg::out_item_t out_data;
  logic               cfg_write = 1'b0;
  logic [7:0]         cfg_data = '0;

  text_console_writer #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  // Shadow console state
  logic [15:0] screen_shadow [SCREEN_CELLS];
  int          cur_row = 0;
  int          cur_col = 0;
  logic [7:0]  text_attr_shadow = tcw_pkg::ATTR_RESET;

  tcw_pkg::out_item_t console_outputs_due [$];
  backlog_entry_t     command_backlog [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int accepted_total = 0;
  int results_total  = 0;
  bit stimulus_done  = 1'b0;
  int error_count    = 0;
  int quiet_cycles   = 0;
  int puts_seen      = 0;
  int reads_seen     = 0;
  int clears_seen    = 0;
  int scrolls_seen   = 0;
  int attr_writes    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] blank_cell();
    return {text_attr_shadow, tcw_pkg::SPACE_CODE};
  endfunction

  // Advance the shadow console by one command and return the result it should produce.
  function automatic tcw_pkg::out_item_t console_apply(input tcw_pkg::in_item_t cmd);
    tcw_pkg::out_item_t res;
    res = '0;
    case (cmd.operation)
      tcw_pkg::OP_PUT: begin
        puts_seen++;
        if (cmd.character == tcw_pkg::NEWLINE_CODE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_shadow[cur_row * SCREEN_COLS + cur_col] = {text_attr_shadow, cmd.character};
          cur_col++;
          if (cur_col >= SCREEN_COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= SCREEN_ROWS) begin
          // shift every row up, blank the bottom one
          for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
            screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
          for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
            screen_shadow[i] = blank_cell();
          cur_row = SCREEN_ROWS - 1;
          cur_col = 0;
          res.scrolled = 1'b1;
          scrolls_seen++;
        end
      end
      tcw_pkg::OP_READ: begin
        reads_seen++;
        if (cmd.cell_index < SCREEN_CELLS)
          res.cell_value = screen_shadow[cmd.cell_index];
      end
      tcw_pkg::OP_CLEAR: begin
        clears_seen++;
        for (int i = 0; i < SCREEN_CELLS; i++)
          screen_shadow[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    res.cursor_row = 5'(cur_row);
    res.cursor_col = 7'(cur_col);
    return res;
  endfunction

  task automatic check_console_output(input tcw_pkg::out_item_t got);
    tcw_pkg::out_item_t want;
    if (console_outputs_due.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("unexpected result: value %h row %0d col %0d scrolled %b",
                 got.cell_value, got.cursor_row, got.cursor_col, got.scrolled);
    end else begin
      want = console_outputs_due.pop_front();
      if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
          got.cursor_col !== want.cursor_col || got.scrolled !== want.scrolled) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("mismatch on result %0d: expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                   results_total, want.cell_value, want.cursor_row, want.cursor_col,
                   want.scrolled, got.cell_value, got.cursor_row, got.cursor_col,
                   got.scrolled);
      end
    end
  endtask

  function automatic void queue_cmd(input logic [1:0] op, input logic [7:0] ch,
                                    input logic [10:0] idx);
    backlog_entry_t e;
    e = '{default: 0, cmd: '0};
    e.cmd.operation  = op;
    e.cmd.character  = ch;
    e.cmd.cell_index = idx;
    command_backlog.push_back(e);
  endfunction

  // Marker: drain everything, then optionally load the attribute and switch idle mix.
  function automatic void queue_marker(input bit cfg_en, input logic [7:0] val,
                                       input int gap, input int stall, input bit last);
    backlog_entry_t e;
    e = '{default: 0, cmd: '0};
    e.marker    = 1'b1;
    e.cfg_en    = cfg_en;
    e.cfg_val   = val;
    e.gap_pct   = gap;
    e.stall_pct = stall;
    e.last      = last;
    command_backlog.push_back(e);
  endfunction

  function automatic void queue_random_cmd();
    int pick;
    logic [10:0] idx;
    pick = $urandom_range(999);
    if (pick < 3)
      queue_cmd(tcw_pkg::OP_CLEAR, 8'($urandom), 11'($urandom));
    else if (pick < 33)
      queue_cmd(OP_UNUSED, 8'($urandom), 11'($urandom));
    else if (pick < 213) begin
      if ($urandom_range(9) == 0)
        idx = 11'($urandom_range(2047, SCREEN_CELLS));
      else
        idx = 11'($urandom_range(SCREEN_CELLS - 1, 0));
      queue_cmd(tcw_pkg::OP_READ, 8'($urandom), idx);
    end else if (pick < 333)
      queue_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 11'($urandom));
    else
      queue_cmd(tcw_pkg::OP_PUT, 8'($urandom), 11'($urandom));
  endfunction

  // Driver: present backlog entries, hold while stalled, run markers once idle.
  always @(posedge clk) begin : driver
    backlog_entry_t head;
    logic next_valid;
    logic next_cfg;
    next_cfg   = 1'b0;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        console_outputs_due.push_back(console_apply(in_data));
        accepted_total <= accepted_total + 1;
        next_valid = 1'b0;
      end
      if (!next_valid && command_backlog.size() != 0) begin
        head = command_backlog[0];
        if (head.marker) begin
          if (!in_valid && accepted_total == results_total) begin
            void'(command_backlog.pop_front());
            if (head.cfg_en) begin
              next_cfg = 1'b1;
              cfg_data <= head.cfg_val;
              text_attr_shadow = head.cfg_val;
              attr_writes++;
            end
            send_idle_pct  <= head.gap_pct;
            recv_stall_pct <= head.stall_pct;
            if (head.last)
              stimulus_done <= 1'b1;
          end
        end else if ($urandom_range(99) >= send_idle_pct) begin
          in_data <= head.cmd;
          void'(command_backlog.pop_front());
          next_valid = 1'b1;
        end
      end
    end
    in_valid  <= next_valid;
    cfg_write <= next_cfg;
  end

  // Monitor: take results under random stall and check them in order.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_total <= results_total + 1;
        check_console_output(out_data);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int         phase_gap [4];
    int         phase_stall [4];
    logic [7:0] phase_attr [4];
    phase_gap   = '{0, 59, 0, 36};
    phase_stall = '{0, 0, 59, 36};
    phase_attr  = '{8'h00, 8'hff, 8'($urandom), 8'($urandom)};

    // Directed: reads touch only cells written so far until the first clear.
    queue_cmd(tcw_pkg::OP_PUT, 8'h41, 11'd0);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::OP_PUT, 8'hff, 11'h7ff);
    queue_cmd(tcw_pkg::OP_PUT, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::OP_READ, 8'hff, 11'd1);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'd2);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'(SCREEN_CELLS));
    queue_cmd(tcw_pkg::OP_READ, 8'hff, 11'h7ff);
    queue_cmd(OP_UNUSED, 8'hff, 11'h7ff);
    queue_cmd(OP_UNUSED, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::OP_CLEAR, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'(SCREEN_CELLS - 1));
    queue_cmd(tcw_pkg::OP_PUT, 8'h5a, 11'd0);
    queue_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 11'h7ff);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
    queue_cmd(tcw_pkg::OP_READ, 8'h00, 11'd1);
    queue_cmd(tcw_pkg::OP_CLEAR, 8'hff, 11'h7ff);

    for (int p = 0; p < 4; p++) begin
      queue_marker(1'b1, phase_attr[p], phase_gap[p], phase_stall[p], 1'b0);
      for (int n = 0; n < RANDOM_COMMANDS / 8; n++)
        queue_random_cmd();
      // pause the sender until every result is back
      queue_marker(1'b0, 8'h00, phase_gap[p], phase_stall[p], 1'b0);
      for (int n = 0; n < RANDOM_COMMANDS / 8; n++)
        queue_random_cmd();
    end
    queue_marker(1'b0, 8'h00, 0, 0, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (!stimulus_done)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (console_outputs_due.size() != 0) begin
      $display("%0d results never arrived", console_outputs_due.size());
      error_count += console_outputs_due.size();
    end
    $display("Ran %0d console commands: %0d puts, %0d reads, %0d clears, %0d scrolls.",
             accepted_total, puts_seen, reads_seen, clears_seen, scrolls_seen);
    $display("Attribute loaded %0d times across four idle/stall mixes; %0d errors.",
             attr_writes, error_count);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_datapath.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
sim/text_console_writer_test.sv
